// ===== rtl/core/sbp_pkg.sv =====
package sbp_pkg;

  localparam int COORD_W = 24;
  localparam int SUM_W = COORD_W + 2;
  localparam int STEP_W = 4;

  localparam logic [63:0] KAPPA_Q32 = 64'd2372044936;

  typedef enum logic {
    REQ_RECT,
    REQ_ELLIPSE
  } req_type_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_SHARP,
    SH_ROUND,
    SH_ELLIPSE
  } shape_t;

  typedef enum logic [1:0] {
    SEG_MOVE,
    SEG_LINE,
    SEG_CUBIC
  } seg_kind_t;

  typedef enum logic [2:0] {
    TM_ZERO,
    TM_ADD_R,
    TM_SUB_R,
    TM_ADD_A,
    TM_SUB_A
  } term_t;

  typedef struct packed {
    logic  on;
    logic  ext;
    term_t term;
  } coord_op_t;

  typedef struct packed {
    seg_kind_t kind;
    logic      last;
    coord_op_t ex;
    coord_op_t ey;
    coord_op_t c1x;
    coord_op_t c1y;
    coord_op_t c2x;
    coord_op_t c2y;
  } seg_plan_t;

  typedef struct packed {
    shape_t                      shape;
    logic signed [COORD_W-1:0]   pos_x;
    logic signed [COORD_W-1:0]   pos_y;
    logic signed [COORD_W-1:0]   size_w;
    logic signed [COORD_W-1:0]   size_h;
    logic signed [COORD_W-1:0]   r_x;
    logic signed [COORD_W-1:0]   r_y;
    logic signed [COORD_W-1:0]   a_x;
    logic signed [COORD_W-1:0]   a_y;
  } job_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    begin
      hi = SUM_W'(2 ** (COORD_W - 1) - 1);
      lo = -SUM_W'(2 ** (COORD_W - 1));
      if (v > hi) begin
        sat_coord = hi[COORD_W-1:0];
      end else if (v < lo) begin
        sat_coord = lo[COORD_W-1:0];
      end else begin
        sat_coord = v[COORD_W-1:0];
      end
    end
  endfunction

endpackage

// ===== rtl/core/sbp_front.sv =====
module sbp_front
  import sbp_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 8,
  parameter int KAPPA_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      req_type,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] size_w,
  input  logic signed [COORD_W-1:0] size_h,
  input  logic signed [COORD_W-1:0] rad_x,
  input  logic signed [COORD_W-1:0] rad_y,
  output logic                      push_valid,
  input  logic                      push_ready,
  output job_t                      push_job
);

  localparam int KW = KAPPA_FRAC_BITS + 1;
  localparam int MW = COORD_W - 1;
  localparam int PW = MW + KW;
  localparam logic [63:0] KAPPA_FULL =
    (KAPPA_Q32 + (64'd1 << (31 - KAPPA_FRAC_BITS))) >> (32 - KAPPA_FRAC_BITS);
  localparam logic [KW-1:0] KAPPA_Q = KW'(KAPPA_FULL);
  localparam logic [KW-1:0] ONE_MINUS_K = KW'((64'd1 << KAPPA_FRAC_BITS) - KAPPA_FULL);
  localparam logic [PW-1:0] ROUND_HALF = PW'(64'd1 << (KAPPA_FRAC_BITS - 1));
  localparam logic signed [COORD_W-1:0] RX_MIN =
    COORD_W'(((64'd1 << COORD_FRAC_BITS) + 64'd99999) / 64'd100000);
  localparam logic signed [COORD_W-1:0] RY_MIN =
    COORD_W'(((64'd1 << COORD_FRAC_BITS) + 64'd9999) / 64'd10000);

  // classify stage
  logic signed [COORD_W-1:0] rx0, ry0, rx1, ry1, rxc, ryc, hw, hh;
  logic [COORD_W:0]          w_sum, h_sum;
  shape_t                    shape_in;
  logic signed [COORD_W-1:0] r_x_in, r_y_in;

  logic                      a_valid;
  shape_t                    a_shape;
  logic signed [COORD_W-1:0] a_pos_x, a_pos_y, a_size_w, a_size_h, a_r_x, a_r_y;

  logic                      b_ready, a_ready;

  // scale stage
  logic [MW-1:0]             mx, my;
  logic [KW-1:0]             coef;
  logic [PW-1:0]             prod_x, prod_y, rnd_x, rnd_y;

  always_comb begin
    rx0 = (rad_x < 0 && rad_y > 0) ? rad_y : rad_x;
    ry0 = (rad_y < 0 && rx0 > 0) ? rx0 : rad_y;
    rx1 = (rx0 < 0) ? '0 : rx0;
    ry1 = (ry0 < 0) ? '0 : ry0;
    w_sum = {size_w[COORD_W-1], size_w} + {{COORD_W{1'b0}}, size_w[COORD_W-1]};
    h_sum = {size_h[COORD_W-1], size_h} + {{COORD_W{1'b0}}, size_h[COORD_W-1]};
    hw = $signed(w_sum[COORD_W:1]);
    hh = $signed(h_sum[COORD_W:1]);
    rxc = (rx1 > hw) ? hw : rx1;
    ryc = (ry1 > hh) ? hh : ry1;
    if (req_type == REQ_ELLIPSE) begin
      r_x_in = rad_x;
      r_y_in = rad_y;
      shape_in = (rad_x > 0 && rad_y > 0) ? SH_ELLIPSE : SH_NONE;
    end else begin
      r_x_in = rxc;
      r_y_in = ryc;
      if (size_w == '0 || size_h == '0) begin
        shape_in = SH_NONE;
      end else if (rxc < RX_MIN || ryc < RY_MIN) begin
        shape_in = SH_SHARP;
      end else begin
        shape_in = SH_ROUND;
      end
    end
  end

  assign b_ready = !push_valid || push_ready;
  assign a_ready = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    mx = (a_r_x > 0) ? a_r_x[MW-1:0] : '0;
    my = (a_r_y > 0) ? a_r_y[MW-1:0] : '0;
    coef = (a_shape == SH_ELLIPSE) ? KAPPA_Q : ONE_MINUS_K;
    prod_x = PW'(mx) * PW'(coef);
    prod_y = PW'(my) * PW'(coef);
    rnd_x = prod_x + ROUND_HALF;
    rnd_y = prod_y + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      push_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid && (shape_in != SH_NONE);
      end
      if (b_ready) begin
        push_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_shape <= shape_in;
      a_pos_x <= pos_x;
      a_pos_y <= pos_y;
      a_size_w <= size_w;
      a_size_h <= size_h;
      a_r_x <= r_x_in;
      a_r_y <= r_y_in;
    end
    if (b_ready && a_valid) begin
      push_job.shape <= a_shape;
      push_job.pos_x <= a_pos_x;
      push_job.pos_y <= a_pos_y;
      push_job.size_w <= a_size_w;
      push_job.size_h <= a_size_h;
      push_job.r_x <= a_r_x;
      push_job.r_y <= a_r_y;
      push_job.a_x <= {1'b0, rnd_x[KAPPA_FRAC_BITS +: MW]};
      push_job.a_y <= {1'b0, rnd_y[KAPPA_FRAC_BITS +: MW]};
    end
  end

endmodule

// ===== rtl/core/sbp_queue.sv =====
module sbp_queue
  import sbp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_fire, pop_fire;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid = (count != '0);
  assign pop_job = slots[rd_ptr];
  assign push_fire = push_valid && push_ready;
  assign pop_fire = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/core/sbp_back.sv =====
module sbp_back
  import sbp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  job_t                      pop_job,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                seg_kind,
  output logic signed [COORD_W-1:0] end_x,
  output logic signed [COORD_W-1:0] end_y,
  output logic signed [COORD_W-1:0] ctl1_x,
  output logic signed [COORD_W-1:0] ctl1_y,
  output logic signed [COORD_W-1:0] ctl2_x,
  output logic signed [COORD_W-1:0] ctl2_y,
  output logic                      last
);

  localparam coord_op_t OFF = '0;

  function automatic coord_op_t co(input logic e, input term_t t);
    coord_op_t o;
    begin
      o.on = 1'b1;
      o.ext = e;
      o.term = t;
      co = o;
    end
  endfunction

  function automatic logic [STEP_W-1:0] last_step(input shape_t s);
    begin
      last_step = (s == SH_ROUND) ? STEP_W'(8) : STEP_W'(4);
    end
  endfunction

  function automatic seg_plan_t seg_plan(input shape_t s, input logic [STEP_W-1:0] st);
    seg_plan_t p;
    begin
      p.kind = SEG_LINE;
      p.last = (st == last_step(s));
      p.ex = co(1'b0, TM_ZERO);
      p.ey = co(1'b0, TM_ZERO);
      p.c1x = OFF;
      p.c1y = OFF;
      p.c2x = OFF;
      p.c2y = OFF;
      case (s)
        SH_ROUND: begin
          case (st)
            4'd0: begin
              p.kind = SEG_MOVE;
              p.ex = co(1'b0, TM_ADD_R);
            end
            4'd1: begin
              p.ex = co(1'b1, TM_SUB_R);
            end
            4'd2: begin
              p.kind = SEG_CUBIC;
              p.ex = co(1'b1, TM_ZERO);
              p.ey = co(1'b0, TM_ADD_R);
              p.c1x = co(1'b1, TM_SUB_A);
              p.c1y = co(1'b0, TM_ZERO);
              p.c2x = co(1'b1, TM_ZERO);
              p.c2y = co(1'b0, TM_ADD_A);
            end
            4'd3: begin
              p.ex = co(1'b1, TM_ZERO);
              p.ey = co(1'b1, TM_SUB_R);
            end
            4'd4: begin
              p.kind = SEG_CUBIC;
              p.ex = co(1'b1, TM_SUB_R);
              p.ey = co(1'b1, TM_ZERO);
              p.c1x = co(1'b1, TM_ZERO);
              p.c1y = co(1'b1, TM_SUB_A);
              p.c2x = co(1'b1, TM_SUB_A);
              p.c2y = co(1'b1, TM_ZERO);
            end
            4'd5: begin
              p.ex = co(1'b0, TM_ADD_R);
              p.ey = co(1'b1, TM_ZERO);
            end
            4'd6: begin
              p.kind = SEG_CUBIC;
              p.ey = co(1'b1, TM_SUB_R);
              p.c1x = co(1'b0, TM_ADD_A);
              p.c1y = co(1'b1, TM_ZERO);
              p.c2x = co(1'b0, TM_ZERO);
              p.c2y = co(1'b1, TM_SUB_A);
            end
            4'd7: begin
              p.ey = co(1'b0, TM_ADD_R);
            end
            default: begin
              p.kind = SEG_CUBIC;
              p.ex = co(1'b0, TM_ADD_R);
              p.c1x = co(1'b0, TM_ZERO);
              p.c1y = co(1'b0, TM_ADD_A);
              p.c2x = co(1'b0, TM_ADD_A);
              p.c2y = co(1'b0, TM_ZERO);
            end
          endcase
        end
        SH_ELLIPSE: begin
          p.kind = SEG_CUBIC;
          case (st)
            4'd0: begin
              p.kind = SEG_MOVE;
              p.ex = co(1'b0, TM_ADD_R);
            end
            4'd1: begin
              p.ey = co(1'b0, TM_ADD_R);
              p.c1x = co(1'b0, TM_ADD_R);
              p.c1y = co(1'b0, TM_ADD_A);
              p.c2x = co(1'b0, TM_ADD_A);
              p.c2y = co(1'b0, TM_ADD_R);
            end
            4'd2: begin
              p.ex = co(1'b0, TM_SUB_R);
              p.c1x = co(1'b0, TM_SUB_A);
              p.c1y = co(1'b0, TM_ADD_R);
              p.c2x = co(1'b0, TM_SUB_R);
              p.c2y = co(1'b0, TM_ADD_A);
            end
            4'd3: begin
              p.ey = co(1'b0, TM_SUB_R);
              p.c1x = co(1'b0, TM_SUB_R);
              p.c1y = co(1'b0, TM_SUB_A);
              p.c2x = co(1'b0, TM_SUB_A);
              p.c2y = co(1'b0, TM_SUB_R);
            end
            default: begin
              p.ex = co(1'b0, TM_ADD_R);
              p.c1x = co(1'b0, TM_ADD_A);
              p.c1y = co(1'b0, TM_SUB_R);
              p.c2x = co(1'b0, TM_ADD_R);
              p.c2y = co(1'b0, TM_SUB_A);
            end
          endcase
        end
        default: begin
          // sharp outline: corner, then clockwise around the box
          case (st)
            4'd0: begin
              p.kind = SEG_MOVE;
            end
            4'd1: begin
              p.ex = co(1'b1, TM_ZERO);
            end
            4'd2: begin
              p.ex = co(1'b1, TM_ZERO);
              p.ey = co(1'b1, TM_ZERO);
            end
            4'd3: begin
              p.ey = co(1'b1, TM_ZERO);
            end
            default: begin
            end
          endcase
        end
      endcase
      seg_plan = p;
    end
  endfunction

  function automatic logic signed [COORD_W-1:0] coord(
    input coord_op_t                 op,
    input logic signed [COORD_W-1:0] base,
    input logic signed [COORD_W-1:0] ext,
    input logic signed [COORD_W-1:0] r,
    input logic signed [COORD_W-1:0] a
  );
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-1:0] e;
    logic signed [SUM_W-1:0] b;
    begin
      b = {{2{base[COORD_W-1]}}, base};
      e = op.ext ? {{2{ext[COORD_W-1]}}, ext} : '0;
      case (op.term)
        TM_ADD_R: t = {{2{r[COORD_W-1]}}, r};
        TM_SUB_R: t = -{{2{r[COORD_W-1]}}, r};
        TM_ADD_A: t = {{2{a[COORD_W-1]}}, a};
        TM_SUB_A: t = -{{2{a[COORD_W-1]}}, a};
        default:  t = '0;
      endcase
      coord = op.on ? sat_coord(b + e + t) : '0;
    end
  endfunction

  job_t              cur;
  logic              busy;
  logic [STEP_W-1:0] step;
  seg_plan_t         plan;
  logic              out_load, pop_fire;

  assign plan = seg_plan(cur.shape, step);
  assign out_load = busy && (!out_valid || out_ready);
  assign pop_ready = !busy || (out_load && plan.last);
  assign pop_fire = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      step <= '0;
    end else begin
      if (pop_fire) begin
        busy <= 1'b1;
        step <= '0;
      end else if (out_load) begin
        busy <= !plan.last;
        step <= step + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      cur <= pop_job;
    end
    if (out_load) begin
      seg_kind <= plan.kind;
      last <= plan.last;
      end_x <= coord(plan.ex, cur.pos_x, cur.size_w, cur.r_x, cur.a_x);
      end_y <= coord(plan.ey, cur.pos_y, cur.size_h, cur.r_y, cur.a_y);
      ctl1_x <= coord(plan.c1x, cur.pos_x, cur.size_w, cur.r_x, cur.a_x);
      ctl1_y <= coord(plan.c1y, cur.pos_y, cur.size_h, cur.r_y, cur.a_y);
      ctl2_x <= coord(plan.c2x, cur.pos_x, cur.size_w, cur.r_x, cur.a_x);
      ctl2_y <= coord(plan.c2y, cur.pos_y, cur.size_h, cur.r_y, cur.a_y);
    end
  end

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= last_step(cur.shape))
    else $error("segment step beyond end of shape");

  a_handover_at_end: assert property (@(posedge clk) disable iff (rst)
    pop_fire && busy |-> out_load && plan.last)
    else $error("new shape taken before previous one finished");

  a_move_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && seg_kind == SEG_MOVE |-> !last)
    else $error("outline closed on a move beat");

endmodule

// ===== rtl/core/shape_to_bezier_path_top.sv =====
// Turns one rectangle or ellipse request per input beat into a closed outline,
// one path segment per output beat: a move, then lines and cubic Beziers, with
// last set on the closing segment. A rounded rectangle gives nine beats, a sharp
// rectangle or an ellipse five, and an empty rectangle or an ellipse without a
// positive radius gives none. The segment sequencer in the back end emits one
// beat per cycle while out_ready does not stall it; new requests keep entering
// through the two-stage front end (radius fix-up and classification, then the
// kappa multiply) and wait in the job queue while it is busy. The first segment
// of an idle block passes the front-end registers, the queue and the job
// register of the back end. Coordinates are Q15.8 and every sum saturates.
module shape_to_bezier_path_top
  import sbp_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 8,
  parameter int KAPPA_FRAC_BITS = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      req_type,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] size_w,
  input  logic signed [COORD_W-1:0] size_h,
  input  logic signed [COORD_W-1:0] rad_x,
  input  logic signed [COORD_W-1:0] rad_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                seg_kind,
  output logic signed [COORD_W-1:0] end_x,
  output logic signed [COORD_W-1:0] end_y,
  output logic signed [COORD_W-1:0] ctl1_x,
  output logic signed [COORD_W-1:0] ctl1_y,
  output logic signed [COORD_W-1:0] ctl2_x,
  output logic signed [COORD_W-1:0] ctl2_y,
  output logic                      last
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  sbp_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .KAPPA_FRAC_BITS(KAPPA_FRAC_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .size_w(size_w),
    .size_h(size_h),
    .rad_x(rad_x),
    .rad_y(rad_y),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job(push_job)
  );

  sbp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job(push_job),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_job(pop_job)
  );

  sbp_back u_back (
    .clk(clk),
    .rst(rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_job(pop_job),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .seg_kind(seg_kind),
    .end_x(end_x),
    .end_y(end_y),
    .ctl1_x(ctl1_x),
    .ctl1_y(ctl1_y),
    .ctl2_x(ctl2_x),
    .ctl2_y(ctl2_y),
    .last(last)
  );

endmodule

// ===== verif/shape_to_bezier_path_top_tb.sv =====
`timescale 1ns / 100ps

import sbp_pkg::*;

localparam int FRAC_BITS = 8;
localparam int KAPPA_BITS = 16;
localparam int WATCHDOG_LIMIT = 2000;

typedef struct {
  req_type_t                 kind;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] w;
  logic signed [COORD_W-1:0] h;
  logic signed [COORD_W-1:0] rx;
  logic signed [COORD_W-1:0] ry;
} shape_req_t;

typedef struct {
  seg_kind_t                 kind;
  logic signed [COORD_W-1:0] ex;
  logic signed [COORD_W-1:0] ey;
  logic signed [COORD_W-1:0] c1x;
  logic signed [COORD_W-1:0] c1y;
  logic signed [COORD_W-1:0] c2x;
  logic signed [COORD_W-1:0] c2y;
  logic                      fin;
} path_seg_t;

class outline_board;
  path_seg_t   segs_due[$];
  int unsigned errors = 0;
  int unsigned beats = 0;
  int unsigned requests = 0;
  int unsigned n_sharp = 0;
  int unsigned n_round = 0;
  int unsigned n_empty = 0;
  int unsigned n_oval = 0;
  int unsigned n_flat_oval = 0;

  function logic signed [COORD_W-1:0] clip(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return v[COORD_W-1:0];
  endfunction

  function longint kappa_frac();
    return (longint'(KAPPA_Q32) + (longint'(1) <<< (31 - KAPPA_BITS))) >>> (32 - KAPPA_BITS);
  endfunction

  function longint arc_offset(input longint r, input longint k);
    if (r <= 0) begin
      return 0;
    end
    return (r * k + (longint'(1) <<< (KAPPA_BITS - 1))) >>> KAPPA_BITS;
  endfunction

  function void add_seg(input seg_kind_t k, input longint ex, input longint ey,
                        input longint c1x, input longint c1y,
                        input longint c2x, input longint c2y, input logic fin);
    path_seg_t s;
    s.kind = k;
    s.ex = clip(ex);
    s.ey = clip(ey);
    s.c1x = clip(c1x);
    s.c1y = clip(c1y);
    s.c2x = clip(c2x);
    s.c2y = clip(c2y);
    s.fin = fin;
    segs_due.push_back(s);
  endfunction

  // works out the outline segments one accepted request gives
  function void note_request(input shape_req_t q);
    longint px, py, w, h, rx, ry, hw, hh, ax, ay, om, kx, ky;
    requests++;
    px = q.px;
    py = q.py;
    w = q.w;
    h = q.h;
    rx = q.rx;
    ry = q.ry;
    if (q.kind == REQ_RECT) begin
      hw = w / 2;
      hh = h / 2;
      // an unset radius borrows the other one
      if (rx < 0 && ry > 0) rx = ry;
      if (ry < 0 && rx > 0) ry = rx;
      if (rx < 0) rx = 0;
      if (ry < 0) ry = 0;
      if (rx > hw) rx = hw;
      if (ry > hh) ry = hh;
      if (w == 0 || h == 0) begin
        n_empty++;
        return;
      end
      if (rx * 100000 < (longint'(1) <<< FRAC_BITS) ||
          ry * 10000 < (longint'(1) <<< FRAC_BITS)) begin
        n_sharp++;
        add_seg(SEG_MOVE, px, py, 0, 0, 0, 0, 1'b0);
        add_seg(SEG_LINE, px + w, py, 0, 0, 0, 0, 1'b0);
        add_seg(SEG_LINE, px + w, py + h, 0, 0, 0, 0, 1'b0);
        add_seg(SEG_LINE, px, py + h, 0, 0, 0, 0, 1'b0);
        add_seg(SEG_LINE, px, py, 0, 0, 0, 0, 1'b1);
        return;
      end
      n_round++;
      om = (longint'(1) <<< KAPPA_BITS) - kappa_frac();
      ax = arc_offset(rx, om);
      ay = arc_offset(ry, om);
      add_seg(SEG_MOVE, px + rx, py, 0, 0, 0, 0, 1'b0);
      add_seg(SEG_LINE, px + w - rx, py, 0, 0, 0, 0, 1'b0);
      add_seg(SEG_CUBIC, px + w, py + ry, px + w - ax, py, px + w, py + ay, 1'b0);
      add_seg(SEG_LINE, px + w, py + h - ry, 0, 0, 0, 0, 1'b0);
      add_seg(SEG_CUBIC, px + w - rx, py + h, px + w, py + h - ay, px + w - ax, py + h, 1'b0);
      add_seg(SEG_LINE, px + rx, py + h, 0, 0, 0, 0, 1'b0);
      add_seg(SEG_CUBIC, px, py + h - ry, px + ax, py + h, px, py + h - ay, 1'b0);
      add_seg(SEG_LINE, px, py + ry, 0, 0, 0, 0, 1'b0);
      add_seg(SEG_CUBIC, px + rx, py, px, py + ay, px + ax, py, 1'b1);
    end else begin
      if (rx <= 0 || ry <= 0) begin
        n_flat_oval++;
        return;
      end
      n_oval++;
      kx = arc_offset(rx, kappa_frac());
      ky = arc_offset(ry, kappa_frac());
      add_seg(SEG_MOVE, px + rx, py, 0, 0, 0, 0, 1'b0);
      add_seg(SEG_CUBIC, px, py + ry, px + rx, py + ky, px + kx, py + ry, 1'b0);
      add_seg(SEG_CUBIC, px - rx, py, px - kx, py + ry, px - rx, py + ky, 1'b0);
      add_seg(SEG_CUBIC, px, py - ry, px - rx, py - ky, px - kx, py - ry, 1'b0);
      add_seg(SEG_CUBIC, px + rx, py, px + kx, py - ry, px + rx, py - ky, 1'b1);
    end
  endfunction

  function void check_segment(input path_seg_t got);
    path_seg_t want;
    beats++;
    if (segs_due.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("beat %0d: segment with none expected, kind %0d end %0d,%0d last %0b",
                 beats, got.kind, got.ex, got.ey, got.fin);
      end
      return;
    end
    want = segs_due.pop_front();
    if (got.kind !== want.kind || got.ex !== want.ex || got.ey !== want.ey ||
        got.c1x !== want.c1x || got.c1y !== want.c1y ||
        got.c2x !== want.c2x || got.c2y !== want.c2y || got.fin !== want.fin) begin
      errors++;
      if (errors <= 10) begin
        $display("beat %0d: segment mismatch", beats);
        $display("  want kind %0d end %0d,%0d c1 %0d,%0d c2 %0d,%0d last %0b",
                 want.kind, want.ex, want.ey, want.c1x, want.c1y, want.c2x, want.c2y,
                 want.fin);
        $display("  got  kind %0d end %0d,%0d c1 %0d,%0d c2 %0d,%0d last %0b",
                 got.kind, got.ex, got.ey, got.c1x, got.c1y, got.c2x, got.c2y, got.fin);
      end
    end
  endfunction
endclass

module shape_to_bezier_path_top_tb;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      req_type;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] size_w;
  logic signed [COORD_W-1:0] size_h;
  logic signed [COORD_W-1:0] rad_x;
  logic signed [COORD_W-1:0] rad_y;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                seg_kind;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic signed [COORD_W-1:0] ctl1_x;
  logic signed [COORD_W-1:0] ctl1_y;
  logic signed [COORD_W-1:0] ctl2_x;
  logic signed [COORD_W-1:0] ctl2_y;
  logic                      last;

  int unsigned in_gap_max = 0;
  int unsigned out_gap_max = 0;
  int unsigned out_hold = 0;
  int unsigned out_draw = 0;
  int unsigned quiet = 0;
  outline_board board;

  shape_to_bezier_path_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic shape_req_t mk(input req_type_t k, input int px, input int py,
                                    input int w, input int h, input int rx, input int ry);
    shape_req_t q;
    q.kind = k;
    q.px = COORD_W'(px);
    q.py = COORD_W'(py);
    q.w = COORD_W'(w);
    q.h = COORD_W'(h);
    q.rx = COORD_W'(rx);
    q.ry = COORD_W'(ry);
    return q;
  endfunction

  function automatic logic signed [COORD_W-1:0] any_coord();
    return COORD_W'($urandom);
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return {1'b0, {(COORD_W-1){1'b1}}};
      1: return {1'b1, {(COORD_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return COORD_W'(1);
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] near_coord();
    if ($urandom_range(0, 9) == 0) begin
      return any_coord();
    end
    return COORD_W'(int'($urandom_range(0, 40000)) - 20000);
  endfunction

  function automatic logic signed [COORD_W-1:0] corner_radius();
    case ($urandom_range(0, 5))
      0: return COORD_W'(-int'($urandom_range(1, 2000)));
      1: return '0;
      2: return COORD_W'($urandom_range(1, 8));
      5: return any_coord();
      default: return COORD_W'($urandom_range(1, 2000));
    endcase
  endfunction

  function automatic shape_req_t random_request();
    shape_req_t  q;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      q.kind = req_type_t'($urandom_range(0, 1));
      q.px = any_coord();
      q.py = any_coord();
      q.w = any_coord();
      q.h = any_coord();
      q.rx = any_coord();
      q.ry = any_coord();
    end else if (sel < 20) begin
      q.kind = req_type_t'($urandom_range(0, 1));
      q.px = pick_extreme();
      q.py = pick_extreme();
      q.w = pick_extreme();
      q.h = pick_extreme();
      q.rx = pick_extreme();
      q.ry = pick_extreme();
    end else if (sel < 60) begin
      q.kind = REQ_RECT;
      q.px = near_coord();
      q.py = near_coord();
      q.w = COORD_W'($urandom_range(1, 6000));
      q.h = COORD_W'($urandom_range(1, 6000));
      if ($urandom_range(0, 9) == 0) q.w = -q.w;
      if ($urandom_range(0, 9) == 0) q.h = -q.h;
      q.rx = corner_radius();
      q.ry = corner_radius();
    end else begin
      q.kind = REQ_ELLIPSE;
      q.px = near_coord();
      q.py = near_coord();
      q.w = any_coord();
      q.h = any_coord();
      q.rx = COORD_W'($urandom_range(1, 5000));
      q.ry = ($urandom_range(0, 3) == 0) ? q.rx : COORD_W'($urandom_range(1, 5000));
      if ($urandom_range(0, 11) == 0) q.ry = COORD_W'(-int'($urandom_range(0, 3)));
    end
    return q;
  endfunction

  task automatic send_request(input shape_req_t q);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= q.kind;
    pos_x <= q.px;
    pos_y <= q.py;
    size_w <= q.w;
    size_h <= q.h;
    rad_x <= q.rx;
    rad_y <= q.ry;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // request side: note accepted beats, watchdog on handshakes
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      board.note_request('{req_type_t'(req_type), pos_x, pos_y, size_w, size_h, rad_x, rad_y});
    end
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // segment side: check each beat, then maybe stall
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold <= 0;
    end else if (out_valid && out_ready) begin
      board.check_segment('{seg_kind_t'(seg_kind), end_x, end_y, ctl1_x, ctl1_y,
                            ctl2_x, ctl2_y, last});
      out_draw = $urandom_range(0, out_gap_max);
      if (out_draw == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        out_hold <= out_draw;
      end
    end else if (!out_ready) begin
      if (out_hold <= 1) begin
        out_ready <= 1'b1;
        out_hold <= 0;
      end else begin
        out_hold <= out_hold - 1;
      end
    end
  end

  initial begin
    board = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= 1'b0;
    pos_x <= '0;
    pos_y <= '0;
    size_w <= '0;
    size_h <= '0;
    rad_x <= '0;
    rad_y <= '0;
    in_gap_max = 3;
    out_gap_max = 3;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_request(mk(REQ_RECT, 0, 0, 2560, 1280, 0, 0));
    send_request(mk(REQ_RECT, 256, -512, 5120, 2560, 512, 256));
    send_request(mk(REQ_RECT, 100, 200, 4000, 3000, -1, 300));
    send_request(mk(REQ_RECT, 100, 200, 4000, 3000, 300, -256));
    send_request(mk(REQ_RECT, 0, 0, 1000, 1000, -5, -7));
    send_request(mk(REQ_RECT, 0, 0, 1001, 600, 9000, 9000));
    send_request(mk(REQ_RECT, 10, 10, 100, 100, 1, 1));
    send_request(mk(REQ_RECT, 0, 0, 500, 500, 0, 40));
    send_request(mk(REQ_RECT, 50, 50, 0, 500, 20, 20));
    send_request(mk(REQ_RECT, 50, 50, 500, 0, 20, 20));
    send_request(mk(REQ_RECT, 1000, 1000, -2000, 1500, 100, 100));
    send_request(mk(REQ_RECT, 1000, 1000, 1500, -2000, 100, 100));
    send_request(mk(REQ_RECT, 0, 0, 7, 9, 100, 100));
    send_request(mk(REQ_RECT, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    send_request(mk(REQ_RECT, -8388608, -8388608, -8388608, -8388608, -8388608, -8388608));
    send_request(mk(REQ_RECT, -8388608, -8388608, 8388607, 8388607, 100, 100));
    send_request(mk(REQ_RECT, -1, -1, -1, -1, -1, -1));
    send_request(mk(REQ_ELLIPSE, 0, 0, 0, 0, 2560, 1280));
    send_request(mk(REQ_ELLIPSE, 1000, -1000, 0, 0, 768, 768));
    send_request(mk(REQ_ELLIPSE, 0, 0, 100, 100, 0, 500));
    send_request(mk(REQ_ELLIPSE, 0, 0, 100, 100, 500, -1));
    send_request(mk(REQ_ELLIPSE, 8388607, -8388608, 0, 0, 8388607, 8388607));
    send_request(mk(REQ_ELLIPSE, -8388608, 8388607, -8388608, 8388607, 1, 1));
    send_request(mk(REQ_ELLIPSE, 5, 5, -1, 8388607, 300, 200));

    for (int n = 0; n < 330; n++) begin
      // idling phases: both sides, none, segment stalls only, request gaps only
      if (n % 40 == 0) begin
        case ((n / 40) % 4)
          0: begin in_gap_max = 8; out_gap_max = 8; end
          1: begin in_gap_max = 0; out_gap_max = 0; end
          2: begin in_gap_max = 0; out_gap_max = 8; end
          default: begin in_gap_max = 8; out_gap_max = 0; end
        endcase
      end
      send_request(random_request());
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (board.segs_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests: %0d sharp, %0d rounded, %0d empty rectangles,",
             board.requests, board.n_sharp, board.n_round, board.n_empty);
    $display("  %0d ellipses, %0d flat ellipses; checked %0d segment beats, %0d errors",
             board.n_oval, board.n_flat_oval, board.beats, board.errors);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sbp_pkg.sv
rtl/core/sbp_front.sv
rtl/core/sbp_queue.sv
rtl/core/sbp_back.sv
rtl/core/shape_to_bezier_path_top.sv
verif/shape_to_bezier_path_top_tb.sv
